// ===== sv/lerq_pkg.sv =====
// Package for the LOOK request queue: sizes, opcodes and shared types.
// No dependencies; every other file but lerq_ram uses it by scoped names.
package lerq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int TRK_W       = 16;
    localparam int TAG_W       = 16;
    localparam int ENT_W       = TRK_W + TAG_W;
    localparam int PCNT_W      = 6;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_SH_RD = 6'b000100,
        ST_SH_WR = 6'b001000,
        ST_RM_RD = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    typedef struct packed {
        logic              queue_empty;
        logic [TRK_W-1:0]  head_track;
        logic [TAG_W-1:0]  head_tag;
        logic [PCNT_W-1:0] pending_count;
        logic              dropped;
    } t_result;

    // Physical slot of the entry n places behind the head of the ring.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                              input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] s;
        s = SUM_W'(h) + SUM_W'(n);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// ===== sv/lerq_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on lerq_pkg for field widths.
interface lerq_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [lerq_pkg::TRK_W-1:0] new_track;
    logic [lerq_pkg::TAG_W-1:0] request_tag;
    modport source (output valid, kind, new_track, request_tag, input ready);
    modport sink   (input valid, kind, new_track, request_tag, output ready);
endinterface

interface lerq_out_if;
    logic                        valid;
    logic                        ready;
    logic                        queue_empty;
    logic [lerq_pkg::TRK_W-1:0]  head_track;
    logic [lerq_pkg::TAG_W-1:0]  head_tag;
    logic [lerq_pkg::PCNT_W-1:0] pending_count;
    logic                        dropped;
    modport source (output valid, queue_empty, head_track, head_tag, pending_count,
                    dropped, input ready);
    modport sink   (input valid, queue_empty, head_track, head_tag, pending_count,
                    dropped, output ready);
endinterface

// ===== sv/lerq_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lerq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/lerq_ctrl.sv =====
// Queue sequencer: LOOK anchor walk, tail-to-anchor shift and head removal
// over a ring held in lerq_ram. Depends on lerq_pkg and lerq_ram.
module lerq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_kind,
    input  logic [lerq_pkg::TRK_W-1:0]  i_track,
    input  logic [lerq_pkg::TAG_W-1:0]  i_tag,
    input  logic                        i_slot_free,
    output logic                        o_res_valid,
    output lerq_pkg::t_result           o_res
);
    lerq_pkg::t_state r_state, n_state;
    logic [lerq_pkg::CNT_W-1:0] r_count, n_count, r_i, n_i, r_pos, n_pos, r_k, n_k;
    logic [lerq_pkg::IDX_W-1:0] r_head, n_head;
    logic [lerq_pkg::TRK_W-1:0] r_head_trk, n_head_trk, r_x, n_x, r_cur, n_cur;
    logic [lerq_pkg::TAG_W-1:0] r_head_tag, n_head_tag, r_tag, n_tag;
    logic r_up, n_up, r_anch, n_anch, r_drop, n_drop;

    logic                       we;
    logic [lerq_pkg::IDX_W-1:0] waddr, raddr;
    logic [lerq_pkg::ENT_W-1:0] wdata, rdata;
    logic [lerq_pkg::TRK_W-1:0] nxt;
    logic [lerq_pkg::CNT_W-1:0] i1;
    logic                       up_n, hit;
    logic [lerq_pkg::CNT_W+lerq_pkg::PCNT_W-1:0] cnt_ext;

    lerq_ram #(.WIDTH(lerq_pkg::ENT_W), .DEPTH(lerq_pkg::QUEUE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign nxt  = rdata[lerq_pkg::ENT_W-1:lerq_pkg::TAG_W];
    assign i1   = r_i + lerq_pkg::CNT_W'(1);
    assign up_n = r_up && !(r_x < r_cur);
    assign hit  = (r_cur == r_x) ||
                  (up_n ? ((r_x <= nxt) || (nxt < r_head_trk))
                        : ((r_x <= r_cur) && (r_x >= nxt)));

    always_comb begin
        n_state = r_state;  n_count = r_count;  n_head = r_head;
        n_head_trk = r_head_trk;  n_head_tag = r_head_tag;
        n_x = r_x;  n_tag = r_tag;  n_i = r_i;  n_cur = r_cur;
        n_up = r_up;  n_anch = r_anch;  n_pos = r_pos;  n_k = r_k;  n_drop = r_drop;
        we = 1'b0;
        waddr = lerq_pkg::phys(r_head, r_k);
        wdata = rdata;
        raddr = lerq_pkg::phys(r_head, r_i + lerq_pkg::CNT_W'(2));
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            lerq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_drop = 1'b0;
                    if (i_kind == lerq_pkg::KIND_INSERT) begin
                        n_x   = i_track;
                        n_tag = i_tag;
                        if (r_count == lerq_pkg::CNT_W'(lerq_pkg::QUEUE_DEPTH)) begin
                            n_drop  = 1'b1;
                            n_state = lerq_pkg::ST_DONE;
                        end else if (r_count >= lerq_pkg::CNT_W'(2)) begin
                            raddr   = lerq_pkg::phys(r_head, lerq_pkg::CNT_W'(1));
                            n_i     = '0;
                            n_cur   = r_head_trk;
                            n_up    = 1'b1;
                            n_anch  = 1'b0;
                            n_state = lerq_pkg::ST_SCAN;
                        end else begin
                            n_pos   = r_count;
                            n_k     = r_count;
                            n_state = lerq_pkg::ST_SH_RD;
                        end
                    end else if (r_count == '0) begin
                        n_state = lerq_pkg::ST_DONE;
                    end else begin
                        // advance the ring head and fetch the new head entry
                        n_head  = lerq_pkg::phys(r_head, lerq_pkg::CNT_W'(1));
                        n_count = r_count - lerq_pkg::CNT_W'(1);
                        raddr   = lerq_pkg::phys(r_head, lerq_pkg::CNT_W'(1));
                        n_state = lerq_pkg::ST_RM_RD;
                    end
                end
            end
            lerq_pkg::ST_SCAN: begin
                // nxt holds the entry after r_i; the read one further on is in flight
                n_k = r_count;
                if (r_anch) begin
                    if ((i1 < r_count) && (nxt == r_x)) begin
                        n_i = i1;
                    end else begin
                        n_pos   = i1;
                        n_state = lerq_pkg::ST_SH_RD;
                    end
                end else if (i1 >= r_count) begin
                    n_pos   = r_count;
                    n_state = lerq_pkg::ST_SH_RD;
                end else if (hit) begin
                    if (nxt == r_x) begin
                        n_anch = 1'b1;
                        n_i    = i1;
                    end else begin
                        n_pos   = i1;
                        n_state = lerq_pkg::ST_SH_RD;
                    end
                end else begin
                    n_up  = up_n;
                    n_cur = nxt;
                    n_i   = i1;
                end
            end
            lerq_pkg::ST_SH_RD: begin
                if (r_k > r_pos) begin
                    raddr   = lerq_pkg::phys(r_head, r_k - lerq_pkg::CNT_W'(1));
                    n_state = lerq_pkg::ST_SH_WR;
                end else begin
                    we      = 1'b1;
                    waddr   = lerq_pkg::phys(r_head, r_pos);
                    wdata   = {r_x, r_tag};
                    n_count = r_count + lerq_pkg::CNT_W'(1);
                    if (r_pos == '0) begin
                        n_head_trk = r_x;
                        n_head_tag = r_tag;
                    end
                    n_state = lerq_pkg::ST_DONE;
                end
            end
            lerq_pkg::ST_SH_WR: begin
                we      = 1'b1;
                n_k     = r_k - lerq_pkg::CNT_W'(1);
                n_state = lerq_pkg::ST_SH_RD;
            end
            lerq_pkg::ST_RM_RD: begin
                n_head_trk = nxt;
                n_head_tag = rdata[lerq_pkg::TAG_W-1:0];
                n_state    = lerq_pkg::ST_DONE;
            end
            lerq_pkg::ST_DONE: begin
                if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    n_state     = lerq_pkg::ST_IDLE;
                end
            end
            default: n_state = lerq_pkg::ST_IDLE;
        endcase
    end

    assign cnt_ext = {{lerq_pkg::PCNT_W{1'b0}}, r_count};
    always_comb begin
        o_res.queue_empty   = (r_count == '0);
        o_res.head_track    = (r_count == '0) ? '0 : r_head_trk;
        o_res.head_tag      = (r_count == '0) ? '0 : r_head_tag;
        o_res.pending_count = cnt_ext[lerq_pkg::PCNT_W-1:0];
        o_res.dropped       = r_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lerq_pkg::ST_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_drop  <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_trk <= n_head_trk;  r_head_tag <= n_head_tag;
        r_x <= n_x;  r_tag <= n_tag;  r_i <= n_i;  r_cur <= n_cur;
        r_up <= n_up;  r_anch <= n_anch;  r_pos <= n_pos;  r_k <= n_k;
    end
endmodule

// ===== sv/look_elevator_request_queue_unit.sv =====
// Channel    | Dir | Payload
// i_req      | in  | kind, new_track, request_tag
// o_rsp      | out | queue_empty, head_track, head_tag, pending_count, dropped
//
// One request at a time. Insert walks the queued entries from the head, then moves every
// entry behind its slot back by one place, all bound by the single RAM read port.
// Reset clears state, count, head pointer, drop flag and result valid only.
// The result register frees the sequencer; a stalled result holds the next one in DONE.
// Depends on lerq_pkg, lerq_if, lerq_ctrl.
module look_elevator_request_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lerq_in_if.sink     i_req,
    lerq_out_if.source  o_rsp
);
    logic              res_valid, slot_free, r_valid;
    lerq_pkg::t_result res, r_res;

    assign slot_free = !r_valid || o_rsp.ready;

    lerq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_kind      (i_req.kind),
        .i_track     (i_req.new_track),
        .i_tag       (i_req.request_tag),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res_valid) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // hold payload until transfer
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_res <= res;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.queue_empty   = r_res.queue_empty;
    assign o_rsp.head_track    = r_res.head_track;
    assign o_rsp.head_tag      = r_res.head_tag;
    assign o_rsp.pending_count = r_res.pending_count;
    assign o_rsp.dropped       = r_res.dropped;
endmodule

// ===== sv/lerq_chk.sv =====
// Port-level checker for the LOOK request queue, bound to the top level.
// Depends on lerq_pkg for widths.
module lerq_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_empty,
    input logic [lerq_pkg::TRK_W-1:0]  i_head_track,
    input logic [lerq_pkg::TAG_W-1:0]  i_head_tag,
    input logic [lerq_pkg::PCNT_W-1:0] i_count,
    input logic                        i_dropped
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transfer");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_empty |-> i_head_track == '0 && i_head_tag == '0
                                   && i_count == '0)
        else $error("empty result carries data");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dropped |-> !i_empty)
        else $error("drop flagged on an empty queue");

    a_count_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_empty && lerq_pkg::QUEUE_DEPTH < 64 |-> i_count != '0)
        else $error("non-empty result with zero count");
endmodule

bind look_elevator_request_queue_unit lerq_chk u_lerq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_empty      (o_rsp.queue_empty),
    .i_head_track (o_rsp.head_track),
    .i_head_tag   (o_rsp.head_tag),
    .i_count      (o_rsp.pending_count),
    .i_dropped    (o_rsp.dropped)
);
